// File: src/ans_pkg.sv
// Shared types and constants for the arpeggio note sequencer.
// No dependencies; compile first.
package ans_pkg;

	localparam int NUM_DEG    = 7;
	localparam int DEG_W      = 3;
	localparam int CHORD_W    = 3;
	localparam int NOTE_W     = 12;
	localparam int STEP_W     = 4;
	localparam int START_W    = 6;
	localparam int PSIZE_W    = 6;
	localparam int METER_W    = 7;
	localparam int NINCL_W    = 3;
	localparam int PCNT_W     = 5;
	localparam int ADV_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic signed [STEP_W-1:0] STEP_MAX  = 4'sd4;
	localparam logic signed [STEP_W-1:0] STEP_MIN  = -4'sd4;
	localparam logic [START_W-1:0]       START_MAX = 6'd40;
	localparam logic [PSIZE_W-1:0]       PSIZE_MAX = 6'd32;

	localparam logic [NINCL_W-1:0] PRIO_RANK [NUM_DEG] =
		'{3'd1, 3'd5, 3'd3, 3'd6, 3'd2, 3'd7, 3'd4};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLOBAL_STEP  = 3'd0,
		REG_PATTERN_STEP = 3'd1,
		REG_START_NOTE   = 3'd2,
		REG_PATTERN_SIZE = 3'd3,
		REG_METER        = 3'd4,
		REG_NOTES_INCL   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic load_mask;
		logic load_sn;
		logic load_cur;
		logic save_cur;
		logic set_adv;
		logic adv_gs;
		logic step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic start_incl;
		logic adv_done;
		logic seq_done;
		logic pat_zero;
		logic out_free;
	} sts_t;

	// degree of a start note, valid for values up to 55
	function automatic logic [DEG_W-1:0] start_deg(input logic [START_W-1:0] v);
		logic [START_W-1:0] r;
		r = v;
		if (r >= 6'd28) r = r - 6'd28;
		if (r >= 6'd14) r = r - 6'd14;
		if (r >= 6'd7)  r = r - 6'd7;
		return r[DEG_W-1:0];
	endfunction

endpackage

// File: src/ans_ifs.sv
// Valid/ready channel interfaces: chord input, note output, register write.
// Depends on ans_pkg.
interface ans_chord_if;
	import ans_pkg::*;
	logic               valid;
	logic               ready;
	logic [CHORD_W-1:0] chord_degree;
	modport source (output valid, output chord_degree, input ready);
	modport sink   (input valid, input chord_degree, output ready);
endinterface

interface ans_note_if;
	import ans_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [NOTE_W-1:0] note;
	logic                     last;
	modport source (output valid, output note, output last, input ready);
	modport sink   (input valid, input note, input last, output ready);
endinterface

interface ans_cfg_if;
	import ans_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/ans_ctrl.sv
// Sequencer state machine: walks start check, note steps and pattern shifts.
// Depends on ans_pkg; drives ans_dp through cmd_t and reads sts_t.
module ans_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output ans_pkg::cmd_t cmd,
	input  ans_pkg::sts_t sts
);
	import ans_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_START, S_SCHK, S_EMIT, S_PSET, S_PRUN, S_LCHK, S_GSET, S_GRUN
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_mask = 1'b1;
					state_nxt     = S_START;
				end
			end
			S_START: begin
				cmd.load_sn = 1'b1;
				state_nxt   = S_SCHK;
			end
			S_SCHK: begin
				state_nxt = sts.start_incl ? S_EMIT : S_PSET;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_PSET;
				end
			end
			S_PSET: begin
				if (sts.seq_done) begin
					state_nxt = S_IDLE;
				end else begin
					cmd.set_adv = 1'b1;
					state_nxt   = S_PRUN;
				end
			end
			S_PRUN: begin
				if (sts.adv_done) state_nxt = S_LCHK;
				else cmd.step = 1'b1;
			end
			S_LCHK: begin
				if (sts.seq_done) state_nxt = S_IDLE;
				else if (sts.pat_zero) state_nxt = S_GSET;
				else state_nxt = S_EMIT;
			end
			S_GSET: begin
				cmd.load_cur = 1'b1;
				cmd.set_adv  = 1'b1;
				cmd.adv_gs   = 1'b1;
				state_nxt    = S_GRUN;
			end
			S_GRUN: begin
				if (sts.adv_done) begin
					cmd.save_cur = 1'b1;
					state_nxt    = S_EMIT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free) else $error("note loaded into a full output slot");
	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !sts.adv_done) else $error("step issued after advance finished");

endmodule

// File: src/ans_dp.sv
// Datapath: config registers, degree mask, note walker, output register.
// Depends on ans_pkg and ans_ifs; commanded by ans_ctrl.
module ans_dp #(
	parameter int MAX_NOTES = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	ans_cfg_if.sink                      cfg,
	ans_note_if.source                   note_out,
	input  logic [ans_pkg::CHORD_W-1:0]  chord_degree,
	input  ans_pkg::cmd_t                cmd,
	output ans_pkg::sts_t                sts
);
	import ans_pkg::*;

	localparam int CW = $clog2(MAX_NOTES + 1);
	localparam int MW = (CW > METER_W) ? CW : METER_W;
	localparam logic [MW-1:0] MT_MAX = MW'(MAX_NOTES);

	logic signed [STEP_W-1:0] gstep_q, pstep_q;
	logic [START_W-1:0]       snote_q;
	logic [PSIZE_W-1:0]       psize_q;
	logic [METER_W-1:0]       meter_q;
	logic [NINCL_W-1:0]       nincl_q;

	logic signed [STEP_W-1:0] gs, ps, sel_step, neg_step;
	logic [START_W-1:0]       sn;
	logic [PSIZE_W-1:0]       psz;
	logic [MW-1:0]            meter_ext, mt_ext;
	logic [CW-1:0]            mt;
	logic [NINCL_W-1:0]       ni;
	logic [NUM_DEG-1:0]       mask_nxt;

	logic [NUM_DEG-1:0]       mask_q;
	logic signed [NOTE_W-1:0] j_q, cur_q;
	logic [DEG_W-1:0]         deg_q, cur_deg_q, deg_nxt;
	logic                     dir_q;
	logic [ADV_W-1:0]         cnt_q;
	logic [CW-1:0]            nn_q;
	logic [PCNT_W-1:0]        pcnt_q;
	logic [PSIZE_W-1:0]       pcnt_inc;
	logic                     out_valid_q;
	logic signed [NOTE_W-1:0] note_q;
	logic                     last_q;
	logic                     out_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gstep_q <= 4'sd1;
			pstep_q <= 4'sd1;
			snote_q <= '0;
			psize_q <= 6'd4;
			meter_q <= 7'd8;
			nincl_q <= 3'd3;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_GLOBAL_STEP:  gstep_q <= cfg.data[STEP_W-1:0];
				REG_PATTERN_STEP: pstep_q <= cfg.data[STEP_W-1:0];
				REG_START_NOTE:   snote_q <= cfg.data[START_W-1:0];
				REG_PATTERN_SIZE: psize_q <= cfg.data[PSIZE_W-1:0];
				REG_METER:        meter_q <= cfg.data[METER_W-1:0];
				REG_NOTES_INCL:   nincl_q <= cfg.data[NINCL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		gs  = (gstep_q < STEP_MIN) ? STEP_MIN : (gstep_q > STEP_MAX) ? STEP_MAX : gstep_q;
		ps  = (pstep_q < STEP_MIN) ? STEP_MIN : (pstep_q > STEP_MAX) ? STEP_MAX : pstep_q;
		sn  = (snote_q > START_MAX) ? START_MAX : snote_q;
		psz = (psize_q == '0) ? PSIZE_W'(1) : (psize_q > PSIZE_MAX) ? PSIZE_MAX : psize_q;
		ni  = (nincl_q == '0) ? NINCL_W'(1) : nincl_q;
		meter_ext = MW'(meter_q);
		mt_ext    = (meter_ext == '0) ? MW'(1) : (meter_ext > MT_MAX) ? MT_MAX : meter_ext;
		mt        = mt_ext[CW-1:0];
		sel_step  = cmd.adv_gs ? gs : ps;
		neg_step  = -sel_step;
	end

	always_comb begin
		logic [DEG_W:0] idx;
		mask_nxt = '0;
		for (int i = 0; i < NUM_DEG; i++) begin
			idx = (DEG_W+1)'(i) + {1'b0, chord_degree};
			if (idx >= (DEG_W+1)'(NUM_DEG)) idx = idx - (DEG_W+1)'(NUM_DEG);
			mask_nxt[idx[DEG_W-1:0]] = (PRIO_RANK[i] <= ni);
		end
	end

	always_comb begin
		if (dir_q) deg_nxt = (deg_q == '0) ? DEG_W'(NUM_DEG - 1) : deg_q - 1'b1;
		else deg_nxt = (deg_q == DEG_W'(NUM_DEG - 1)) ? '0 : deg_q + 1'b1;
	end

	assign out_free = !out_valid_q || note_out.ready;
	assign pcnt_inc = PSIZE_W'(pcnt_q) + PSIZE_W'(1);

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_mask) mask_q <= mask_nxt;
		if (cmd.load_sn) begin
			j_q       <= NOTE_W'(sn);
			deg_q     <= start_deg(sn);
			cur_q     <= NOTE_W'(sn);
			cur_deg_q <= start_deg(sn);
		end else if (cmd.load_cur) begin
			j_q   <= cur_q;
			deg_q <= cur_deg_q;
		end else if (cmd.step) begin
			j_q   <= dir_q ? j_q - NOTE_W'(1) : j_q + NOTE_W'(1);
			deg_q <= deg_nxt;
		end
		if (cmd.save_cur) begin
			cur_q     <= j_q;
			cur_deg_q <= deg_q;
		end
		if (cmd.set_adv) dir_q <= sel_step[STEP_W-1];
		if (cmd.emit) begin
			note_q <= j_q;
			last_q <= (nn_q + CW'(1)) == mt;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			nn_q        <= '0;
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_adv) begin
				cnt_q <= sel_step[STEP_W-1] ? neg_step[ADV_W-1:0] : sel_step[ADV_W-1:0];
			end else if (cmd.step && mask_q[deg_nxt]) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.load_sn) begin
				nn_q   <= '0;
				pcnt_q <= '0;
			end else if (cmd.emit) begin
				nn_q   <= nn_q + CW'(1);
				pcnt_q <= (pcnt_inc == psz) ? '0 : pcnt_inc[PCNT_W-1:0];
			end
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (note_out.ready) out_valid_q <= 1'b0;
		end
	end

	assign note_out.valid = out_valid_q;
	assign note_out.note  = note_q;
	assign note_out.last  = last_q;

	assign sts.start_incl = mask_q[deg_q];
	assign sts.adv_done   = (cnt_q == '0);
	assign sts.seq_done   = (nn_q == mt);
	assign sts.pat_zero   = (pcnt_q == '0);
	assign sts.out_free   = out_free;

	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_mask |=> (mask_q != '0)) else $error("empty degree mask");
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (nn_q < mt)) else $error("note emitted past sequence length");

endmodule

// File: src/arpeggio_note_sequencer_core.sv
// Arpeggio note sequencer top: one chord in, meter notes out (meter clamped to 1..MAX_NOTES).
// First note: loaded in S_EMIT after S_START and S_SCHK (start included), else after both walks.
// Each further note walks the pattern step in S_PRUN, one scale position per step
// (up to 7 per included-degree step), plus the shift walk in S_GRUN at each pattern start.
// One chord at a time; the next is taken in S_IDLE, reached via S_PSET after the last note is loaded.
// arst_n clears the sequencer state and loads the register defaults; no clearing pass.
module arpeggio_note_sequencer_core #(
	parameter int MAX_NOTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ans_chord_if.sink   chord_in,
	ans_note_if.source  note_out,
	ans_cfg_if.sink     cfg
);
	import ans_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign chord_in.ready = in_ready;

	ans_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chord_in.valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ans_dp #(
		.MAX_NOTES (MAX_NOTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.note_out     (note_out),
		.chord_degree (chord_in.chord_degree),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule
